FILE: hdl/two_class_priority_ticket_queue_assert.svh
// Assertion macros shared by the ticket queue modules
`ifndef TWO_CLASS_PRIORITY_TICKET_QUEUE_ASSERT_SVH
`define TWO_CLASS_PRIORITY_TICKET_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define TCPQ_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tcpq assertion failed");

// next-cycle implication, disabled while reset is low
`define TCPQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tcpq assertion failed");

`endif

FILE: hdl/tcpq_pkg.sv
// Types and constants of the two-class ticket queue
`default_nettype none
package tcpq_pkg;

	localparam int ID_W     = 27;
	localparam int TICKET_W = 16;
	localparam int STATUS_W = 3;
	localparam int CMD_W    = 2;

	localparam logic [CMD_W-1:0] CMD_ENQ_URGENT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENQ_REGULAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SERVE       = 2'd2;

	localparam logic [STATUS_W-1:0] ST_ENQUEUED       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SERVED_URGENT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SERVED_REGULAR = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTHING        = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL           = 3'd4;

	localparam logic [TICKET_W-1:0] TICKET_FIRST = 16'd1;
	localparam logic [TICKET_W-1:0] TICKET_MAX   = 16'hFFFF;

	typedef struct packed {
		logic push;
		logic pop;
	} cq_ctrl_t;

	typedef struct packed {
		logic                empty;
		logic                full;
		logic [TICKET_W-1:0] push_ticket;
		logic [TICKET_W-1:0] pop_ticket;
	} cq_stat_t;

	// tickets skip zero on wrap
	function automatic logic [TICKET_W-1:0] ticket_after(input logic [TICKET_W-1:0] t);
		logic [TICKET_W-1:0] r;
		if (t == TICKET_MAX) begin
			r = TICKET_FIRST;
		end else begin
			r = t + TICKET_W'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/two_class_priority_ticket_queue.sv
// Top level: two-class strict-priority ticket queue
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------
//  in      | in_valid / in_stall  | command, client_id
//  out     | out_valid / out_stall| status, ticket, served_id
//
// One item per cycle sustained while out_stall is low; each item passes
// through the input register, then the result register.
// Each class FIFO is a memory with a registered read that prefetches the
// next head, so back-to-back serves do not wait on the read port.
// Reset clears counts, heads and tickets at once; memories need no clearing.
// out_stall holds the result register and backs up into in_stall.
`default_nettype none
module two_class_priority_ticket_queue
	import tcpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [CMD_W-1:0]    command,
	input  wire logic [ID_W-1:0]     client_id,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [STATUS_W-1:0]      status,
	output logic [TICKET_W-1:0]      ticket,
	output logic [ID_W-1:0]          served_id
);

	logic                valid_s1;
	logic [CMD_W-1:0]    command_s1;
	logic [ID_W-1:0]     client_id_s1;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [TICKET_W-1:0] ticket_q;
	logic [ID_W-1:0]     served_id_q;

	logic                advance;
	logic                fire;
	logic                load_s1;
	cq_ctrl_t            urg_ctrl;
	cq_ctrl_t            reg_ctrl;
	cq_stat_t            urg_stat;
	cq_stat_t            reg_stat;
	logic [ID_W-1:0]     urg_head_id;
	logic [ID_W-1:0]     reg_head_id;
	logic [STATUS_W-1:0] status_d;
	logic [TICKET_W-1:0] ticket_d;
	logic [ID_W-1:0]     served_id_d;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	always_comb begin
		urg_ctrl    = '0;
		reg_ctrl    = '0;
		status_d    = ST_NOTHING;
		ticket_d    = '0;
		served_id_d = '0;
		case (command_s1)
			CMD_ENQ_URGENT: begin
				urg_ctrl.push = fire;
				if (urg_stat.full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_ENQUEUED;
					ticket_d = urg_stat.push_ticket;
				end
			end
			CMD_ENQ_REGULAR: begin
				reg_ctrl.push = fire;
				if (reg_stat.full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_ENQUEUED;
					ticket_d = reg_stat.push_ticket;
				end
			end
			CMD_SERVE: begin
				if (!urg_stat.empty) begin
					urg_ctrl.pop = fire;
					status_d     = ST_SERVED_URGENT;
					ticket_d     = urg_stat.pop_ticket;
					served_id_d  = urg_head_id;
				end else if (!reg_stat.empty) begin
					reg_ctrl.pop = fire;
					status_d     = ST_SERVED_REGULAR;
					ticket_d     = reg_stat.pop_ticket;
					served_id_d  = reg_head_id;
				end
			end
			default: begin
				status_d = ST_NOTHING;
			end
		endcase
	end

	tcpq_class_queue #(.DEPTH(QUEUE_DEPTH)) u_urgent (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (urg_ctrl),
		.push_id (client_id_s1),
		.stat    (urg_stat),
		.head_id (urg_head_id)
	);

	tcpq_class_queue #(.DEPTH(QUEUE_DEPTH)) u_regular (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (reg_ctrl),
		.push_id (client_id_s1),
		.stat    (reg_stat),
		.head_id (reg_head_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			command_s1   <= command;
			client_id_s1 <= client_id;
		end
		if (fire) begin
			status_q    <= status_d;
			ticket_q    <= ticket_d;
			served_id_q <= served_id_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign ticket    = ticket_q;
	assign served_id = served_id_q;

`include "two_class_priority_ticket_queue_assert.svh"

	`TCPQ_ASSERT_NEXT(a_urgent_first, clk, arst_n, fire && (command_s1 == CMD_SERVE) && !urg_stat.empty, out_valid_q && (status_q == ST_SERVED_URGENT))
	`TCPQ_ASSERT_NOW(a_no_push_pop_mix, clk, arst_n, urg_ctrl.pop || reg_ctrl.pop, !urg_ctrl.push && !reg_ctrl.push)
	`TCPQ_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire, out_valid_q)

endmodule
`default_nettype wire

FILE: hdl/tcpq_class_queue.sv
// One priority class: id FIFO memory, head/count, ticket counters
`default_nettype none
module tcpq_class_queue
	import tcpq_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cq_ctrl_t        ctrl,
	input  wire logic [ID_W-1:0] push_id,
	output cq_stat_t             stat,
	output logic [ID_W-1:0]      head_id
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [ID_W-1:0]     mem_q [DEPTH];
	logic [ID_W-1:0]     head_id_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       head_d;
	logic [AW-1:0]       head_inc;
	logic [AW-1:0]       tail;
	logic [SW-1:0]       tail_sum;
	logic [CW-1:0]       count_q;
	logic [TICKET_W-1:0] next_ticket_q;
	logic [TICKET_W-1:0] serve_ticket_q;
	logic                full;
	logic                empty;
	logic                do_push;
	logic                do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = ctrl.push && !full;
	assign do_pop   = ctrl.pop && !empty;

	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign head_d   = do_pop ? head_inc : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q         <= '0;
			count_q        <= '0;
			next_ticket_q  <= TICKET_FIRST;
			serve_ticket_q <= TICKET_FIRST;
		end else begin
			head_q <= head_d;
			if (do_push) begin
				count_q       <= count_q + CW'(1);
				next_ticket_q <= ticket_after(next_ticket_q);
			end else if (do_pop) begin
				count_q        <= count_q - CW'(1);
				serve_ticket_q <= ticket_after(serve_ticket_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[tail] <= push_id;
		end
	end

	// prefetch the entry that is head after this cycle; a push into an empty
	// queue lands on that very slot, so forward it
	always_ff @(posedge clk) begin
		if (do_push && (tail == head_d)) begin
			head_id_q <= push_id;
		end else begin
			head_id_q <= mem_q[head_d];
		end
	end

	assign head_id          = head_id_q;
	assign stat.empty       = empty;
	assign stat.full        = full;
	assign stat.push_ticket = next_ticket_q;
	assign stat.pop_ticket  = serve_ticket_q;

`include "two_class_priority_ticket_queue_assert.svh"

	`TCPQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`TCPQ_ASSERT_NOW(a_pop_nonempty, clk, arst_n, ctrl.pop, !empty)
	`TCPQ_ASSERT_NOW(a_one_op, clk, arst_n, ctrl.push, !ctrl.pop)
	`TCPQ_ASSERT_NEXT(a_full_keeps, clk, arst_n, ctrl.push && full, $stable(count_q) && $stable(next_ticket_q))

endmodule
`default_nettype wire
